// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the boundary force block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define WRBF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define WRBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/wrbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbf_pkg
// Types, constants and helper functions of the radial boundary force block.
// ----------------------------------------------------------------------------
package wrbf_pkg;

  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_CENTER_Z    = 3'd2;
  localparam logic [2:0] REG_RADIUS      = 3'd3;
  localparam logic [2:0] REG_WALL_K      = 3'd4;
  localparam logic [2:0] REG_MORSE_DEPTH = 3'd5;
  localparam logic [2:0] REG_MORSE_ALPHA = 3'd6;

  localparam logic [31:0] LN2_FRAC   = 32'hB172_17F8;
  // floor(2^64 / LN2_FRAC), used to estimate the range reduction quotient.
  localparam logic [33:0] RECIP_LN2  = 34'd6196328018;
  localparam logic [32:0] ONE_FRAC   = 33'h1_0000_0000;
  localparam logic [46:0] MAX47      = {47{1'b1}};
  localparam logic [61:0] MAX62      = {62{1'b1}};
  localparam logic [46:0] EXP_LIMIT  = 47'd1507328;
  localparam logic [3:0]  EXP_TERMS  = 4'd12;
  localparam logic [32:0] UNIT_ONE   = 33'h0_4000_0000;

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             excluded;
    logic             last;
  } wrbf_item_t;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] radius;
    logic [31:0] wall_k;
    logic [31:0] depth;
    logic [31:0] alpha;
  } wrbf_cfg_t;

  // floor(2^34 / k) for the Horner divisors above two.
  function automatic logic [32:0] recip34(input logic [3:0] k);
    logic [32:0] m;
    case (k)
      4'd3:    m = 33'd5726623061;
      4'd4:    m = 33'd4294967296;
      4'd5:    m = 33'd3435973836;
      4'd6:    m = 33'd2863311530;
      4'd7:    m = 33'd2454267026;
      4'd8:    m = 33'd2147483648;
      4'd9:    m = 33'd1908874353;
      4'd10:   m = 33'd1717986918;
      4'd11:   m = 33'd1561806289;
      4'd12:   m = 33'd1431655765;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [47:0] sat48(input logic [63:0] v);
    logic [47:0] r;
    if (!v[63] && (|v[62:47])) begin
      r = {1'b0, {47{1'b1}}};
    end else if (v[63] && !(&v[62:47])) begin
      r = {1'b1, {47{1'b0}}};
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic [55:0] sat56(input logic [56:0] v);
    logic [55:0] r;
    if (v[56] != v[55]) begin
      r = v[56] ? {1'b1, {55{1'b0}}} : {1'b0, {55{1'b1}}};
    end else begin
      r = v[55:0];
    end
    return r;
  endfunction

endpackage

// File: src/wrbf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbf_front
// Accepts oxygen positions and forms the signed offset to the sphere center.
// ----------------------------------------------------------------------------
module wrbf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  wrbf_pkg::wrbf_cfg_t cfg,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [95:0]        in_tdata,
  input  logic               in_tuser,
  input  logic               in_tlast,
  output logic               item_valid,
  input  logic               item_ready,
  output wrbf_pkg::wrbf_item_t item
);
  import wrbf_pkg::*;

  wrbf_item_t  item_r;
  logic        valid_r;
  wrbf_item_t  item_w;
  logic [32:0] d_x, d_y, d_z;
  logic [32:0] a_x, a_y, a_z;

  assign d_x = {in_tdata[31], in_tdata[31:0]}   - {cfg.center_x[31], cfg.center_x};
  assign d_y = {in_tdata[63], in_tdata[63:32]}  - {cfg.center_y[31], cfg.center_y};
  assign d_z = {in_tdata[95], in_tdata[95:64]}  - {cfg.center_z[31], cfg.center_z};
  assign a_x = d_x[32] ? 33'd0 - d_x : d_x;
  assign a_y = d_y[32] ? 33'd0 - d_y : d_y;
  assign a_z = d_z[32] ? 33'd0 - d_z : d_z;

  always_comb begin
    item_w.mag[0]   = a_x[31:0];
    item_w.mag[1]   = a_y[31:0];
    item_w.mag[2]   = a_z[31:0];
    item_w.neg      = {d_z[32], d_y[32], d_x[32]};
    item_w.excluded = in_tuser;
    item_w.last     = in_tlast;
  end

  assign in_tready  = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        valid_r <= 1'b1;
        item_r  <= item_w;
      end else if (item_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: src/wrbf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbf_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wrbf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  wrbf_pkg::wrbf_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output wrbf_pkg::wrbf_item_t pop_item
);
  import wrbf_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  wrbf_item_t      mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push, pop;

  assign push_ready = count_r != CntW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_item;
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `WRBF_ASSERT_IMPL(a_q_bound, clk, rst_n, 1'b1, count_r <= CntW'(DEPTH))
  `WRBF_ASSERT_NEXT(a_q_grow, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

// File: src/wrbf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbf_mul
// Shared 64 by 34 bit multiplier built from two 32 by 34 bit partial products.
// ----------------------------------------------------------------------------
module wrbf_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [33:0] b,
  output logic        done,
  output logic [97:0] p
);

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SUM} mstate_t;

  mstate_t     state_r;
  logic [63:0] a_r;
  logic [33:0] b_r;
  logic [65:0] lo_r, hi_r, prod;
  logic [97:0] p_r;
  logic        done_r;

  assign prod = ((state_r == M_LO) ? a_r[31:0] : a_r[63:32]) * b_r;
  assign done = done_r;
  assign p    = p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            a_r     <= a;
            b_r     <= b;
            state_r <= M_LO;
          end
        end
        M_LO: begin
          lo_r    <= prod;
          state_r <= M_HI;
        end
        M_HI: begin
          hi_r    <= prod;
          state_r <= M_SUM;
        end
        M_SUM: begin
          p_r     <= {hi_r, 32'h0} + {32'h0, lo_r};
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

endmodule

// File: src/wrbf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbf_div
// Restoring divider, one quotient bit per cycle, quotient out.
// ----------------------------------------------------------------------------
module wrbf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [33:0] divisor,
  input  logic [5:0]  nbits,
  output logic        done,
  output logic [32:0] quo
);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t     state_r;
  logic [34:0] rem_r;
  logic [63:0] dvd_r;
  logic [33:0] dvs_r;
  logic [32:0] quo_r;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic [34:0] trial;
  logic        ge;

  assign trial = {rem_r[33:0], dvd_r[63]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            rem_r   <= 35'(dividend >> nbits);
            dvd_r   <= dividend << (7'd64 - {1'b0, nbits});
            dvs_r   <= divisor;
            quo_r   <= '0;
            cnt_r   <= nbits;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= ge ? trial - {1'b0, dvs_r} : trial;
          quo_r <= {quo_r[31:0], ge};
          dvd_r <= {dvd_r[62:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 6'd1) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

// File: src/wrbf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbf_back
// Sequencer for distance, wall or Morse term, forces and the energy total.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wrbf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wrbf_pkg::wrbf_cfg_t  cfg,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  wrbf_pkg::wrbf_item_t item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [247:0]         out_tdata,
  output logic                 out_tlast
);
  import wrbf_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE, B_SQ, B_SQRT, B_CLASS, B_H_GF, B_H_EP, B_M_T, B_M_RED, B_M_HA,
    B_M_HB, B_M_HC, B_M_F2, B_M_DA, B_M_EN, B_M_G, B_F_CHK, B_F_U, B_F_M, B_OUT
  } bstate_t;

  bstate_t           state_r;
  wrbf_item_t        item_r;
  logic [1:0]        idx_r;
  logic [63:0]       s_r, res_r;
  logic [4:0]        it_r;
  logic [32:0]       b_r, db_r;
  logic              inward_r, issued_r;
  logic [48:0]       gf_r;
  logic [46:0]       g_r;
  logic [47:0]       energy_r;
  logic [20:0]       t_r;
  logic [5:0]        n_r;
  logic [31:0]       r_r, x_r, q0_r;
  logic [32:0]       e_r, f_r, f2_r;
  logic [3:0]        k_r;
  logic [47:0]       da_r;
  logic [30:0]       u_r;
  logic [2:0][47:0]  force_r;
  logic [55:0]       acc_r;
  logic              out_valid_r, out_last_r;
  logic [247:0]      out_data_r;

  logic        mul_use, mul_start, mul_done;
  logic [63:0] mul_a;
  logic [33:0] mul_b;
  logic [97:0] mul_p;
  logic        div_use, div_start, div_done;
  logic [63:0] div_dvd;
  logic [33:0] div_dvs;
  logic [5:0]  div_nbits;
  logic [32:0] div_quo;

  logic [63:0] bitv, sq_trial;
  logic [32:0] b_w;
  logic [31:0] q_w, kx_w;
  logic [32:0] e_w;
  logic [46:0] m_w, pe_w;
  logic [55:0] acc_w;
  logic        out_load;
  logic [63:0] big_w;
  logic [5:0]  nq_w;
  logic [37:0] nl_w;
  logic [33:0] rr_w;

  wrbf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  wrbf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .nbits    (div_nbits),
    .done     (div_done),
    .quo      (div_quo)
  );

  always_comb begin
    mul_use   = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_use   = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    div_nbits = '0;
    case (state_r)
      B_SQ: begin
        mul_use = 1'b1;
        mul_a   = 64'(item_r.mag[idx_r]);
        mul_b   = 34'(item_r.mag[idx_r]);
      end
      B_H_GF: begin
        mul_use = 1'b1;
        mul_a   = 64'(cfg.wall_k);
        mul_b   = 34'(db_r);
      end
      B_H_EP: begin
        mul_use = 1'b1;
        mul_a   = 64'(gf_r);
        mul_b   = 34'(db_r);
      end
      B_M_T: begin
        mul_use = 1'b1;
        mul_a   = 64'(cfg.alpha);
        mul_b   = 34'(db_r);
      end
      B_M_RED: begin
        mul_use = 1'b1;
        mul_a   = big_w;
        mul_b   = RECIP_LN2;
      end
      B_M_HA: begin
        mul_use = 1'b1;
        mul_a   = 64'(r_r);
        mul_b   = 34'(e_r);
      end
      B_M_HB: begin
        mul_use = k_r > 4'd2;
        mul_a   = 64'(x_r);
        mul_b   = 34'(recip34(k_r));
      end
      B_M_F2: begin
        mul_use = 1'b1;
        mul_a   = 64'(f_r);
        mul_b   = 34'(f_r);
      end
      B_M_DA: begin
        mul_use = 1'b1;
        mul_a   = 64'(cfg.depth);
        mul_b   = 34'(cfg.alpha);
      end
      B_M_EN: begin
        mul_use = 1'b1;
        mul_a   = 64'(cfg.depth);
        mul_b   = {f_r, 1'b0} - 34'(f2_r);
      end
      B_M_G: begin
        mul_use = 1'b1;
        mul_a   = 64'(da_r);
        mul_b   = 34'(f_r - f2_r);
      end
      B_F_U: begin
        div_use   = 1'b1;
        div_dvd   = {2'b00, item_r.mag[idx_r], 30'h0};
        div_dvs   = 34'(b_r);
        div_nbits = 6'd33;
      end
      B_F_M: begin
        mul_use = 1'b1;
        mul_a   = 64'(g_r);
        mul_b   = 34'(u_r);
      end
      default: ;
    endcase
  end

  assign mul_start = mul_use && !issued_r;
  assign div_start = div_use && !issued_r;

  assign bitv     = 64'(1) << (6'd62 - {it_r, 1'b0});
  assign sq_trial = res_r + bitv;
  assign b_w      = {res_r[31:0], 1'b0};
  assign kx_w     = 32'(q0_r * k_r);
  assign q_w      = ((x_r - kx_w) >= 32'(k_r)) ? q0_r + 1'b1 : q0_r;
  assign e_w      = ONE_FRAC - {1'b0, q_w};
  assign m_w      = (|mul_p[97:77]) ? MAX47 : mul_p[76:30];
  assign pe_w     = (|mul_p[97:79]) ? MAX47 : mul_p[78:32];
  assign acc_w    = sat56({acc_r[55], acc_r} + {{9{energy_r[47]}}, energy_r});
  assign out_load = (state_r == B_OUT) && (!out_valid_r || out_tready);

  // The reciprocal estimate is the exact quotient or one below it.
  assign big_w = {27'h0, t_r, 16'h0};
  assign nq_w  = mul_p[69:64];
  assign nl_w  = {32'h0, nq_w} * {6'h0, LN2_FRAC};
  assign rr_w  = 34'(big_w[37:0] - nl_w);

  assign item_ready = state_r == B_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      if (mul_start || div_start) begin
        issued_r <= 1'b1;
      end else if (mul_done || div_done) begin
        issued_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (item_valid) begin
            item_r   <= item;
            s_r      <= '0;
            idx_r    <= '0;
            g_r      <= '0;
            energy_r <= '0;
            force_r  <= '0;
            state_r  <= B_SQ;
          end
        end
        B_SQ: begin
          if (mul_done) begin
            s_r <= s_r + 64'(mul_p[63:2]);
            if (idx_r == 2'd2) begin
              res_r   <= '0;
              it_r    <= '0;
              state_r <= B_SQRT;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        B_SQRT: begin
          if (s_r >= sq_trial) begin
            s_r   <= s_r - sq_trial;
            res_r <= (res_r >> 1) + bitv;
          end else begin
            res_r <= res_r >> 1;
          end
          it_r <= it_r + 1'b1;
          if (it_r == 5'd31) begin
            state_r <= B_CLASS;
          end
        end
        B_CLASS: begin
          b_r <= b_w;
          if (item_r.excluded || (b_w == '0)) begin
            state_r <= B_OUT;
          end else if (b_w > 33'(cfg.radius)) begin
            db_r     <= b_w - 33'(cfg.radius);
            inward_r <= 1'b0;
            state_r  <= B_H_GF;
          end else begin
            db_r     <= 33'(cfg.radius) - b_w;
            inward_r <= 1'b1;
            state_r  <= B_M_T;
          end
        end
        B_H_GF: begin
          if (mul_done) begin
            gf_r    <= mul_p[64:16];
            g_r     <= (|mul_p[64:63]) ? MAX47 : mul_p[62:16];
            state_r <= B_H_EP;
          end
        end
        B_H_EP: begin
          if (mul_done) begin
            energy_r <= sat48({2'b00, ((|mul_p[97:79]) ? MAX62 : mul_p[78:17])}
                              - 64'(cfg.depth));
            state_r  <= B_F_CHK;
          end
        end
        B_M_T: begin
          if (mul_done) begin
            if (mul_p[62:16] >= EXP_LIMIT) begin
              f_r     <= '0;
              state_r <= B_M_F2;
            end else begin
              t_r     <= mul_p[36:16];
              state_r <= B_M_RED;
            end
          end
        end
        B_M_RED: begin
          if (mul_done) begin
            if (rr_w >= 34'(LN2_FRAC)) begin
              n_r <= nq_w + 1'b1;
              r_r <= 32'(rr_w - 34'(LN2_FRAC));
            end else begin
              n_r <= nq_w;
              r_r <= rr_w[31:0];
            end
            e_r     <= ONE_FRAC;
            k_r     <= EXP_TERMS;
            state_r <= B_M_HA;
          end
        end
        B_M_HA: begin
          if (mul_done) begin
            x_r     <= mul_p[63:32];
            state_r <= B_M_HB;
          end
        end
        B_M_HB: begin
          if (k_r <= 4'd2) begin
            q0_r    <= (k_r == 4'd2) ? (x_r >> 1) : x_r;
            state_r <= B_M_HC;
          end else if (mul_done) begin
            q0_r    <= mul_p[65:34];
            state_r <= B_M_HC;
          end
        end
        B_M_HC: begin
          e_r <= e_w;
          if (k_r == 4'd1) begin
            f_r     <= e_w >> n_r;
            state_r <= B_M_F2;
          end else begin
            k_r     <= k_r - 1'b1;
            state_r <= B_M_HA;
          end
        end
        B_M_F2: begin
          if (mul_done) begin
            f2_r    <= mul_p[64:32];
            state_r <= B_M_DA;
          end
        end
        B_M_DA: begin
          if (mul_done) begin
            da_r    <= mul_p[63:16];
            state_r <= B_M_EN;
          end
        end
        B_M_EN: begin
          if (mul_done) begin
            energy_r <= 48'd0 - {1'b0, pe_w};
            state_r  <= B_M_G;
          end
        end
        B_M_G: begin
          if (mul_done) begin
            g_r     <= (|mul_p[97:78]) ? MAX47 : mul_p[77:31];
            state_r <= B_F_CHK;
          end
        end
        B_F_CHK: begin
          idx_r   <= '0;
          state_r <= (g_r == '0) ? B_OUT : B_F_U;
        end
        B_F_U: begin
          if (div_done) begin
            u_r     <= (div_quo > UNIT_ONE) ? UNIT_ONE[30:0] : div_quo[30:0];
            state_r <= B_F_M;
          end
        end
        B_F_M: begin
          if (mul_done) begin
            force_r[idx_r] <= (item_r.neg[idx_r] != inward_r) ? 48'd0 - {1'b0, m_w}
                                                             : {1'b0, m_w};
            if (idx_r == 2'd2) begin
              state_r <= B_OUT;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= B_F_U;
            end
          end
        end
        B_OUT: begin
          if (out_load) begin
            out_data_r  <= {acc_w, energy_r, force_r[2], force_r[1], force_r[0]};
            out_last_r  <= item_r.last;
            acc_r       <= item_r.last ? '0 : acc_w;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  `WRBF_ASSERT_IMPL(a_mul_owned, clk, rst_n, mul_done, issued_r && !div_done)
  `WRBF_ASSERT_IMPL(a_div_owned, clk, rst_n, div_done, issued_r)
  `WRBF_ASSERT_NEXT(a_acc_clear, clk, rst_n, out_load && item_r.last, acc_r == '0)

endmodule

// File: src/water_radial_boundary_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_radial_boundary_force
// Spherical solvent boundary restraint: wall or Morse force on water oxygens.
// ----------------------------------------------------------------------------
// One oxygen position goes in per word and one force and energy word comes out.
// Words are taken into a small queue while the sequencer works, so input and
// output stall independently. The work per item is set by the 32-step square
// root, the bit-serial divider (33 steps per force component) and, in the Morse
// region, the 12-term exponential series; all products go through one shared
// multiplier, one at a time. The running energy total is reported with each
// word and cleared after the word with tlast.
module water_radial_boundary_force #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // pos_x, pos_y, pos_z
  input  logic         in_tuser,   // excluded
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [247:0] out_tdata,  // force_x, force_y, force_z, atom_energy, energy_sum
  output logic         out_tlast
);
  import wrbf_pkg::*;

  wrbf_cfg_t  cfg_r;
  wrbf_item_t f_item, q_item;
  logic       f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CENTER_X:    cfg_r.center_x <= cfg_wdata;
        REG_CENTER_Y:    cfg_r.center_y <= cfg_wdata;
        REG_CENTER_Z:    cfg_r.center_z <= cfg_wdata;
        REG_RADIUS:      cfg_r.radius   <= cfg_wdata[30:0];
        REG_WALL_K:      cfg_r.wall_k   <= cfg_wdata;
        REG_MORSE_DEPTH: cfg_r.depth    <= cfg_wdata;
        REG_MORSE_ALPHA: cfg_r.alpha    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  wrbf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  wrbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  wrbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: tb/water_radial_boundary_force_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_radial_boundary_force_tb
// Self-checking bench for the spherical boundary restraint block.
// ----------------------------------------------------------------------------
// Oxygen positions are streamed through the block under several register
// settings and idling patterns. A bit-exact predictor computes the force,
// energy and running total of each accepted word, and every result word is
// compared field by field with the oldest prediction.
module water_radial_boundary_force_tb;
  import wrbf_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 500;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [63:0] CAP47 = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] CAP62 = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CAP64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] UNITY = 64'h1_0000_0000;

  typedef struct {
    logic [31:0] x, y, z;
    bit excluded, last;
  } atom_t;

  typedef struct {
    logic [47:0] fx, fy, fz, energy;
    logic [55:0] sum;
    bit done;
  } force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;  // pos_x, pos_y, pos_z
  logic in_tuser = 1'b0;       // excluded
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [247:0] out_tdata;     // force_x, force_y, force_z, atom_energy, energy_sum
  logic out_tlast;

  water_radial_boundary_force DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longint ctr[3];
  logic [63:0] radius, wall_k, depth, alpha;
  longint energy_total;

  atom_t pending_atoms[$];
  force_t expected_forces[$];
  atom_t held;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go = 1'b0;
  bit holding = 1'b0;
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int totals_seen = 0;
  int settings = 0;
  longint cycles = 0;

  function automatic longint clamp_signed(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh,
                                                 logic [63:0] cap);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p[127:64] != 0) return cap;
    return p[63:0] > cap ? cap : p[63:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] decay(logic [63:0] t);
    logic [63:0] big, n, r, e, ln2;
    ln2 = {32'd0, LN2_FRAC};
    e = UNITY;
    if (t >= (64'd23 << 16)) return 0;
    big = t << 16;
    n = big / ln2;
    r = big - n * ln2;
    for (int k = EXP_TERMS; k >= 1; k--) begin
      e = UNITY - ((r * e) >> 32) / k;
    end
    return e >> n;
  endfunction

  function automatic force_t boundary_force(atom_t a);
    force_t res;
    longint d[3], f[3], energy;
    logic [63:0] ad[3], sq, s, b, g, db, gf, ep, t, fe, f2, da, u, m;
    bit inward, act;
    d[0] = longint'($signed(a.x)) - ctr[0];
    d[1] = longint'($signed(a.y)) - ctr[1];
    d[2] = longint'($signed(a.z)) - ctr[2];
    s = 0;
    g = 0;
    energy = 0;
    inward = 0;
    act = 0;
    for (int i = 0; i < 3; i++) begin
      f[i] = 0;
      ad[i] = d[i] < 0 ? -d[i] : d[i];
      sq = ad[i] * ad[i];
      s = s + (sq >> 2);
    end
    b = root64(s) << 1;
    if (!a.excluded) begin
      if (b > radius) begin
        db = b - radius;
        gf = scaled_product(wall_k, db, 16, CAP64);
        ep = scaled_product(gf, db, 17, CAP62);
        g = gf > CAP47 ? CAP47 : gf;
        energy = clamp_signed(longint'(ep) - longint'(depth), 48);
        act = 1;
      end else if (b > 0) begin
        db = radius - b;
        t = (alpha * db) >> 16;
        fe = decay(t);
        f2 = scaled_product(fe, fe, 32, CAP64);
        da = (depth * alpha) >> 16;
        energy = -longint'(scaled_product(depth, 2 * fe - f2, 32, CAP47));
        g = scaled_product(da, fe - f2, 31, CAP47);
        inward = 1;
        act = 1;
      end
    end
    if (act && g != 0) begin
      for (int i = 0; i < 3; i++) begin
        u = (ad[i] << 30) / b;
        if (u > (64'd1 << 30)) u = 64'd1 << 30;
        m = scaled_product(g, u, 30, CAP47);
        f[i] = ((d[i] < 0) != inward) ? -longint'(m) : longint'(m);
      end
    end
    energy_total = clamp_signed(energy_total + energy, 56);
    res.fx = f[0][47:0];
    res.fy = f[1][47:0];
    res.fz = f[2][47:0];
    res.energy = energy[47:0];
    res.sum = energy_total[55:0];
    res.done = a.last;
    if (a.last) energy_total = 0;
    return res;
  endfunction

  // Input side: keeps a word on the bus until it is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_forces.push_back(boundary_force(held));
        words_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_atoms.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          held = pending_atoms.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {held.z, held.y, held.x};
          in_tuser <= held.excluded;
          in_tlast <= held.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each word and throttles tready.
  always @(posedge clk) begin
    force_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        words_out++;
        if (out_tlast) totals_seen++;
        if (expected_forces.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h", $time, out_tdata);
        end else begin
          want = expected_forces.pop_front();
          if (out_tdata[47:0] !== want.fx) begin
            errors++;
            $display("%0t: force_x expected %h actual %h", $time, want.fx, out_tdata[47:0]);
          end
          if (out_tdata[95:48] !== want.fy) begin
            errors++;
            $display("%0t: force_y expected %h actual %h", $time, want.fy, out_tdata[95:48]);
          end
          if (out_tdata[143:96] !== want.fz) begin
            errors++;
            $display("%0t: force_z expected %h actual %h", $time, want.fz, out_tdata[143:96]);
          end
          if (out_tdata[191:144] !== want.energy) begin
            errors++;
            $display("%0t: atom_energy expected %h actual %h", $time, want.energy,
                     out_tdata[191:144]);
          end
          if (out_tdata[247:192] !== want.sum) begin
            errors++;
            $display("%0t: energy_sum expected %h actual %h", $time, want.sum,
                     out_tdata[247:192]);
          end
          if (out_tlast !== want.done) begin
            errors++;
            $display("%0t: pass_done expected %b actual %b", $time, want.done, out_tlast);
          end
        end
      end
      if (holding) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Long receiver hold-off, counted in cycles on its own.
  initial begin
    wait (hold_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    case (addr)
      REG_CENTER_X: ctr[0] = longint'($signed(val));
      REG_CENTER_Y: ctr[1] = longint'($signed(val));
      REG_CENTER_Z: ctr[2] = longint'($signed(val));
      REG_RADIUS: radius = {33'd0, val[30:0]};
      REG_WALL_K: wall_k = {32'd0, val};
      REG_MORSE_DEPTH: depth = {32'd0, val};
      REG_MORSE_ALPHA: alpha = {32'd0, val};
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] r, logic [31:0] k, logic [31:0] dp,
                           logic [31:0] al);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, r);
    write_reg(REG_WALL_K, k);
    write_reg(REG_MORSE_DEPTH, dp);
    write_reg(REG_MORSE_ALPHA, al);
    write_reg(REG_UNUSED, $urandom);
    settings++;
  endtask

  task automatic add_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit ex, bit lst);
    atom_t a;
    a.x = x;
    a.y = y;
    a.z = z;
    a.excluded = ex;
    a.last = lst;
    pending_atoms.push_back(a);
  endtask

  // Mostly positions scattered around the sphere shell, with some at the
  // center, some anywhere in the coordinate range and some excluded.
  task automatic add_random_atoms(int n);
    logic [31:0] p[3];
    longint span;
    int kind;
    span = radius == 0 ? 64'd10 << 16 : radius * 3 / 2;
    if (span > (64'd1 << 30)) span = 64'd1 << 30;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      for (int j = 0; j < 3; j++) begin
        if (kind < 10) p[j] = $urandom;
        else if (kind < 18) p[j] = ctr[j][31:0];
        else p[j] = ctr[j][31:0] + 32'($urandom_range(0, 2 * span) - span);
      end
      add_atom(p[0], p[1], p[2], $urandom_range(99) < 10, $urandom_range(99) < 6);
    end
  endtask

  task automatic drain;
    while (pending_atoms.size() > 0 || in_tvalid || expected_forces.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(int s_pct, int r_pct, int n);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    configure($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF),
              $urandom, $urandom_range(0, 32'h0100_0000),
              $urandom_range(32'h0001_0000, 32'h0028_0000),
              $urandom_range(0, 32'h0064_0000), $urandom_range(0, 32'h000A_0000),
              $urandom_range(0, 32'h0004_0000));
    add_random_atoms(n);
    add_atom(ctr[0][31:0], ctr[1][31:0], ctr[2][31:0], 0, 1);
    drain();
  endtask

  initial begin
    ctr[0] = 0;
    ctr[1] = 0;
    ctr[2] = 0;
    radius = 0;
    wall_k = 0;
    depth = 0;
    alpha = 0;
    energy_total = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at their reset values.
    add_atom(32'h0001_0000, 32'h0, 32'h0, 0, 0);
    add_atom(32'h0, 32'h0, 32'h0, 0, 1);
    drain();

    configure(32'h0, 32'h0, 32'h0, 32'h000A_0000, 32'h0002_0000, 32'h0001_0000,
              32'h0001_8000);
    add_atom(32'h0, 32'h0, 32'h0, 0, 0);
    add_atom(32'h0014_0000, 32'h0, 32'h0, 1, 0);
    add_atom(32'h0001_0000, 32'h0, 32'h0, 0, 0);
    add_atom(32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_C000, 0, 0);
    add_atom(32'h000A_0000, 32'h0, 32'h0, 0, 0);
    add_atom(32'h0, 32'hFFF6_0000, 32'h0, 0, 0);
    add_atom(32'h0014_0000, 32'hFFFB_0000, 32'h0003_0000, 0, 0);
    add_atom(32'h0000_0001, 32'h0, 32'h0, 0, 1);
    add_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    add_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
    add_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0, 0);
    add_atom(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1, 1);
    add_atom(32'h0009_FFFF, 32'h0, 32'h0, 0, 1);
    drain();

    // Extreme register values.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0, 0);
    add_atom(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0, 0);
    add_atom(32'h8000_0001, 32'h7FFF_FFFF, 32'h0, 0, 0);
    add_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    add_atom(32'h0, 32'h0, 32'h8000_0000, 0, 1);
    add_random_atoms(60);
    add_atom(32'h0, 32'h0, 32'h0, 0, 1);
    drain();

    configure(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
    add_random_atoms(30);
    drain();

    run_phase(0, 0, 400);
    run_phase(84, 0, 350);
    run_phase(0, 84, 350);
    run_phase(25, 25, 400);

    // Receiver held off while words keep coming, so the input stalls.
    hold_go = 1'b1;
    run_phase(0, 0, 400);

    $display("Run covered %0d words in, %0d out, %0d register settings, %0d pass totals.",
             words_in, words_out, settings, totals_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
